// ===== hdl/pdd_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the top-1 pose detection decoder.
// Depends on nothing; all other files but pdd_ram refer to it by scoped names.

package pdd_pkg;

   // Record layout
   localparam int NUM_KP     = 17;
   localparam int VALUE_W    = 16;
   localparam int KP_BASE    = 5;
   localparam int KP_STRIDE  = 3;
   localparam int REC_LEN    = KP_BASE + KP_STRIDE * NUM_KP;
   localparam int CONF_IDX   = 4;
   localparam int BOX_READS  = 4;
   localparam int KP_READS   = 3;
   localparam int IDX_W      = 6;
   localparam int ENTRY_W    = $clog2(REC_LEN);
   localparam int KP_W       = (NUM_KP > 1) ? $clog2(NUM_KP) : 1;

   // Record store: three banks per entry, addressed as {bank, entry}
   localparam int NUM_BANKS  = 3;
   localparam int BANK_W     = 2;
   localparam int RAM_DEPTH  = NUM_BANKS << ENTRY_W;
   localparam int RAM_AW     = BANK_W + ENTRY_W;

   // Configuration widths and reset values
   localparam int THR_W      = 15;
   localparam int PAD_W      = 15;
   localparam int INV_W      = 24;
   localparam int CSR_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int THR_RESET  = 8192;
   localparam int PAD_RESET  = 0;
   localparam int INV_RESET  = 65536;

   // Result widths
   localparam int KIND_W     = 2;
   localparam int PN_W       = 5;
   localparam int COORD_W    = 19;
   localparam int SCORE_W    = 15;
   localparam int SCORE_MAX  = (1 << SCORE_W) - 1;

   // Letterbox arithmetic
   localparam int DIFF_BASE  = (VALUE_W > PAD_W + 1) ? VALUE_W : PAD_W + 1;
   localparam int DIFF_W     = DIFF_BASE + 3;
   localparam int PROD_W     = DIFF_W + INV_W + 1;
   localparam int RND_SHIFT  = 17;
   localparam int RND_HALF   = 1 << (RND_SHIFT - 1);
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

   // Result queue depth
   localparam int RSP_DEPTH  = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_BOX  = 2'd0,
      KIND_KP   = 2'd1,
      KIND_NONE = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONF_THR  = 2'd0,
      CSR_PAD_X     = 2'd1,
      CSR_PAD_Y     = 2'd2,
      CSR_INV_SCALE = 2'd3
   } csr_index_type;

   typedef logic [BANK_W-1:0] bank_type;
   typedef logic [REC_LEN-1:0][BANK_W-1:0] bank_vec_type;

   typedef struct packed {
      logic [THR_W-1:0] conf_threshold;
      logic [PAD_W-1:0] pad_x;
      logic [PAD_W-1:0] pad_y;
      logic [INV_W-1:0] inv_scale;
   } cfg_type;

   // Frame job handed from the front to the back
   typedef struct packed {
      logic                      valid;
      logic                      have_best;
      logic signed [VALUE_W-1:0] score;
   } job_type;

   // Back status seen by the front
   typedef struct packed {
      logic take;
      logic busy;
   } back_stat_type;

   typedef struct packed {
      kind_type                  kind;
      logic [PN_W-1:0]           point_number;
      logic signed [COORD_W-1:0] x_first;
      logic signed [COORD_W-1:0] y_first;
      logic signed [COORD_W-1:0] x_second;
      logic signed [COORD_W-1:0] y_second;
      logic [SCORE_W-1:0]        score;
      logic                      last_result;
   } result_type;

   // Lowest bank that holds neither of the two protected copies
   function automatic bank_type free_bank(input bank_type keep_a, input bank_type keep_b);
      bank_type f;
      f = BANK_W'(NUM_BANKS - 1);
      for (int i = NUM_BANKS - 1; i >= 0; i--) begin
         if (BANK_W'(i) != keep_a && BANK_W'(i) != keep_b) begin
            f = BANK_W'(i);
         end
      end
      return f;
   endfunction

   // Round a Q.22 product half up to Q.5 and clamp to the coordinate range
   function automatic logic signed [COORD_W-1:0] round_sat(
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [PROD_W:0]           p;
      logic signed [PROD_W-RND_SHIFT:0] q;
      logic signed [COORD_W-1:0]        r;
      p = (PROD_W+1)'(prod) + (PROD_W+1)'(RND_HALF);
      q = p[PROD_W:RND_SHIFT];
      if (q < COORD_MIN) begin
         r = COORD_MIN;
      end else if (q > COORD_MAX) begin
         r = COORD_MAX;
      end else begin
         r = COORD_W'(q);
      end
      return r;
   endfunction

   // Clamp a confidence to [0, SCORE_MAX]
   function automatic logic [SCORE_W-1:0] sat_score(input logic signed [VALUE_W-1:0] s);
      logic [SCORE_W-1:0] r;
      if (int'(s) < 0) begin
         r = '0;
      end else if (int'(s) > SCORE_MAX) begin
         r = SCORE_W'(SCORE_MAX);
      end else begin
         r = SCORE_W'(s);
      end
      return r;
   endfunction

endpackage

// ===== hdl/pose_top1_detection_decode_unit.sv =====
`timescale 1ns / 1ps
// Top-1 pose detection decoder. Feature beats are taken one per cycle while full is low;
// full rises only when a frame ends while the previous frame is still being emitted and
// holds until the back end takes it. The back end reads the record RAM one entry per cycle
// and shares one multiplier; result stalls hold it.
// Reset is synchronous: it clears control state and restores register defaults.

module pose_top1_detection_decode_unit (
   input  logic                                clock,
   input  logic                                reset,
   // feature input
   input  logic                                push,
   output logic                                full,
   input  logic signed [pdd_pkg::VALUE_W-1:0]  req_feature_value,
   input  logic [pdd_pkg::IDX_W-1:0]           req_feature_index,
   input  logic                                req_frame_end,
   // result output
   output logic                                empty,
   input  logic                                pop,
   output logic [pdd_pkg::KIND_W-1:0]          rsp_kind,
   output logic [pdd_pkg::PN_W-1:0]            rsp_point_number,
   output logic signed [pdd_pkg::COORD_W-1:0]  rsp_x_first,
   output logic signed [pdd_pkg::COORD_W-1:0]  rsp_y_first,
   output logic signed [pdd_pkg::COORD_W-1:0]  rsp_x_second,
   output logic signed [pdd_pkg::COORD_W-1:0]  rsp_y_second,
   output logic [pdd_pkg::SCORE_W-1:0]         rsp_score,
   output logic                                rsp_last_result,
   // register writes
   input  logic                                csr_wr_en,
   input  logic [pdd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdd_pkg::CSR_W-1:0]           csr_wdata
);

   pdd_pkg::cfg_type       cfg_ff, cfg_in;
   pdd_pkg::job_type       job;
   pdd_pkg::back_stat_type stat;
   pdd_pkg::bank_vec_type  emit_sel;
   pdd_pkg::result_type    res;
   pdd_pkg::result_type    rsp;

   logic                          wr_en;
   logic [pdd_pkg::RAM_AW-1:0]    wr_addr;
   logic [pdd_pkg::VALUE_W-1:0]   wr_data;
   logic                          rd_en;
   logic [pdd_pkg::RAM_AW-1:0]    rd_addr;
   logic [pdd_pkg::VALUE_W-1:0]   rd_data;
   logic                          res_push;
   logic                          res_full;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (pdd_pkg::csr_index_type'(csr_index))
            pdd_pkg::CSR_CONF_THR:  cfg_in.conf_threshold = csr_wdata[pdd_pkg::THR_W-1:0];
            pdd_pkg::CSR_PAD_X:     cfg_in.pad_x          = csr_wdata[pdd_pkg::PAD_W-1:0];
            pdd_pkg::CSR_PAD_Y:     cfg_in.pad_y          = csr_wdata[pdd_pkg::PAD_W-1:0];
            pdd_pkg::CSR_INV_SCALE: cfg_in.inv_scale      = csr_wdata[pdd_pkg::INV_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_threshold <= pdd_pkg::THR_W'(pdd_pkg::THR_RESET);
         cfg_ff.pad_x          <= pdd_pkg::PAD_W'(pdd_pkg::PAD_RESET);
         cfg_ff.pad_y          <= pdd_pkg::PAD_W'(pdd_pkg::PAD_RESET);
         cfg_ff.inv_scale      <= pdd_pkg::INV_W'(pdd_pkg::INV_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pdd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .feature_value (req_feature_value),
      .feature_index (req_feature_index),
      .frame_end     (req_frame_end),
      .cfg           (cfg_ff),
      .stat          (stat),
      .job           (job),
      .emit_sel      (emit_sel),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data)
   );

   pdd_ram #(
      .WIDTH (pdd_pkg::VALUE_W),
      .DEPTH (pdd_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pdd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .job      (job),
      .emit_sel (emit_sel),
      .stat     (stat),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .res_full (res_full),
      .res_push (res_push),
      .res      (res)
   );

   pdd_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res),
      .full  (res_full),
      .pop   (pop),
      .empty (empty),
      .dout  (rsp)
   );

   // Result beat fields
   assign rsp_kind         = rsp.kind;
   assign rsp_point_number = rsp.point_number;
   assign rsp_x_first      = rsp.x_first;
   assign rsp_y_first      = rsp.y_first;
   assign rsp_x_second     = rsp.x_second;
   assign rsp_y_second     = rsp.y_second;
   assign rsp_score        = rsp.score;
   assign rsp_last_result  = rsp.last_result;

endmodule

// ===== hdl/pdd_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Depends on nothing; sized by its parameters.

module pdd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hdl/pdd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts feature beats, stores them in the record RAM, tracks the best box
// per frame by bank pointers and queues one frame job for the back end. Uses pdd_pkg.

module pdd_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic signed [pdd_pkg::VALUE_W-1:0] feature_value,
   input  logic [pdd_pkg::IDX_W-1:0]          feature_index,
   input  logic                               frame_end,
   input  pdd_pkg::cfg_type                   cfg,
   input  pdd_pkg::back_stat_type             stat,
   output pdd_pkg::job_type                   job,
   output pdd_pkg::bank_vec_type              emit_sel,
   output logic                               wr_en,
   output logic [pdd_pkg::RAM_AW-1:0]         wr_addr,
   output logic [pdd_pkg::VALUE_W-1:0]        wr_data
);

   // Per-entry bank pointers: current record, best record, record under emission
   pdd_pkg::bank_vec_type cur_sel_ff, cur_sel_in;
   pdd_pkg::bank_vec_type best_sel_ff, best_sel_in;
   pdd_pkg::bank_vec_type emit_sel_ff, emit_sel_in;

   logic signed [pdd_pkg::VALUE_W-1:0] cur_conf_ff, cur_conf_in;
   logic signed [pdd_pkg::VALUE_W-1:0] best_score_ff, best_score_in;
   logic                               have_best_ff, have_best_in;

   // One-deep job queue toward the back end
   logic                               pend_valid_ff, pend_valid_in;
   logic                               pend_have_best_ff, pend_have_best_in;
   logic signed [pdd_pkg::VALUE_W-1:0] pend_score_ff, pend_score_in;

   logic                         accept;
   logic                         in_range;
   logic [pdd_pkg::ENTRY_W-1:0]  entry;
   pdd_pkg::bank_type            lock_bank;
   pdd_pkg::bank_type            free;
   logic                         close;
   logic                         keep;

   // Input handshake: stall only while a finished frame waits for the back end
   assign full   = pend_valid_ff && !stat.take;
   assign accept = push && !full;

   // Pick a bank for the new beat that holds neither the best nor the emitted copy
   always_comb begin
      in_range  = int'(feature_index) < pdd_pkg::REC_LEN;
      entry     = pdd_pkg::ENTRY_W'(feature_index);
      lock_bank = stat.busy ? emit_sel_ff[entry] : best_sel_ff[entry];
      free      = pdd_pkg::free_bank(best_sel_ff[entry], lock_bank);
   end

   assign wr_en   = accept && in_range;
   assign wr_addr = {free, entry};
   assign wr_data = feature_value;

   // Record close, best tracking and frame hand-off
   always_comb begin
      cur_sel_in = cur_sel_ff;
      if (wr_en) begin
         cur_sel_in[entry] = free;
      end

      cur_conf_in = cur_conf_ff;
      if (wr_en && int'(feature_index) == pdd_pkg::CONF_IDX) begin
         cur_conf_in = feature_value;
      end

      close = accept && (int'(feature_index) == pdd_pkg::REC_LEN - 1 || frame_end);
      keep  = close && int'(cur_conf_in) > int'(best_score_ff)
                    && int'(cur_conf_in) > int'(cfg.conf_threshold);

      best_sel_in   = keep ? cur_sel_in : best_sel_ff;
      best_score_in = keep ? cur_conf_in : best_score_ff;
      have_best_in  = keep || have_best_ff;

      // Lock the best pointers for emission when the back end takes the job
      emit_sel_in = stat.take ? best_sel_ff : emit_sel_ff;

      pend_valid_in     = pend_valid_ff && !stat.take;
      pend_have_best_in = pend_have_best_ff;
      pend_score_in     = pend_score_ff;

      if (accept && frame_end) begin
         pend_valid_in     = 1'b1;
         pend_have_best_in = have_best_in;
         pend_score_in     = best_score_in;
         // clear per-frame state
         cur_conf_in       = '0;
         best_score_in     = '0;
         have_best_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_sel_ff     <= '0;
         best_sel_ff    <= '0;
         emit_sel_ff    <= '0;
         cur_conf_ff    <= '0;
         best_score_ff  <= '0;
         have_best_ff   <= 1'b0;
         pend_valid_ff  <= 1'b0;
      end else begin
         cur_sel_ff     <= cur_sel_in;
         best_sel_ff    <= best_sel_in;
         emit_sel_ff    <= emit_sel_in;
         cur_conf_ff    <= cur_conf_in;
         best_score_ff  <= best_score_in;
         have_best_ff   <= have_best_in;
         pend_valid_ff  <= pend_valid_in;
      end
   end

   // Job payload
   always_ff @(posedge clock) begin
      pend_have_best_ff <= pend_have_best_in;
      pend_score_ff     <= pend_score_in;
   end

   assign job.valid     = pend_valid_ff;
   assign job.have_best = pend_have_best_ff;
   assign job.score     = pend_score_ff;
   assign emit_sel      = emit_sel_ff;

endmodule

// ===== hdl/pdd_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer that reads the best record from the record RAM, undoes the letterbox
// with one shared multiplier and pushes box and keypoint results. Uses pdd_pkg.

module pdd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pdd_pkg::cfg_type            cfg,
   input  pdd_pkg::job_type            job,
   input  pdd_pkg::bank_vec_type       emit_sel,
   output pdd_pkg::back_stat_type      stat,
   output logic                        rd_en,
   output logic [pdd_pkg::RAM_AW-1:0]  rd_addr,
   input  logic [pdd_pkg::VALUE_W-1:0] rd_data,
   input  logic                        res_full,
   output logic                        res_push,
   output pdd_pkg::result_type         res
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_READ  = 7'b0000010,
      ST_WAIT  = 7'b0000100,
      ST_DIFF  = 7'b0001000,
      ST_MUL   = 7'b0010000,
      ST_ROUND = 7'b0100000,
      ST_PUSH  = 7'b1000000
   } back_state_type;

   localparam int SLOT_W = 2;

   back_state_type state_ff, state_in;

   logic                             none_ff, none_in;
   logic                             is_box_ff, is_box_in;
   logic [pdd_pkg::KP_W-1:0]         kp_ff, kp_in;
   logic [pdd_pkg::ENTRY_W-1:0]      base_ff, base_in;
   logic [SLOT_W-1:0]                slot_ff, slot_in;
   logic [SLOT_W-1:0]                cc_ff, cc_in;
   logic                             cap_valid_ff;
   logic [SLOT_W-1:0]                cap_slot_ff;
   logic signed [pdd_pkg::VALUE_W-1:0] score_ff;
   logic signed [pdd_pkg::VALUE_W-1:0] opnd_ff [pdd_pkg::BOX_READS];
   logic signed [pdd_pkg::DIFF_W-1:0]  diff_ff;
   logic signed [pdd_pkg::PROD_W-1:0]  prod_ff;
   logic signed [pdd_pkg::COORD_W-1:0] coord_ff [pdd_pkg::BOX_READS];

   logic [pdd_pkg::ENTRY_W-1:0]        rd_entry;
   logic [SLOT_W-1:0]                  last_slot;
   logic [SLOT_W-1:0]                  last_cc;
   logic                               last_kp;
   logic signed [pdd_pkg::VALUE_W-1:0] cen;
   logic signed [pdd_pkg::VALUE_W-1:0] ext;
   logic [pdd_pkg::PAD_W-1:0]          pad;
   logic signed [pdd_pkg::DIFF_W-1:0]  cen_x;
   logic signed [pdd_pkg::DIFF_W-1:0]  ext_x;
   logic [pdd_pkg::DIFF_W-1:0]         pad_x2;
   logic signed [pdd_pkg::DIFF_W-1:0]  diff;
   logic signed [pdd_pkg::INV_W:0]     inv_s;
   logic signed [pdd_pkg::PROD_W-1:0]  prod;

   assign stat.take = (state_ff == ST_IDLE) && job.valid;
   assign stat.busy = (state_ff != ST_IDLE);

   // Record RAM read: one entry per cycle from the locked bank
   assign rd_entry  = base_ff + pdd_pkg::ENTRY_W'(slot_ff);
   assign rd_en     = (state_ff == ST_READ);
   assign rd_addr   = {emit_sel[rd_entry], rd_entry};

   assign last_slot = is_box_ff ? SLOT_W'(pdd_pkg::BOX_READS - 1)
                                : SLOT_W'(pdd_pkg::KP_READS - 1);
   assign last_cc   = is_box_ff ? SLOT_W'(3) : SLOT_W'(1);
   assign last_kp   = (int'(kp_ff) == pdd_pkg::NUM_KP - 1);

   // Corner or point difference in Q.6: 2*center +/- extent - 2*pad
   always_comb begin
      cen    = cc_ff[0] ? opnd_ff[1] : opnd_ff[0];
      ext    = is_box_ff ? (cc_ff[0] ? opnd_ff[3] : opnd_ff[2]) : '0;
      pad    = cc_ff[0] ? cfg.pad_y : cfg.pad_x;
      cen_x  = pdd_pkg::DIFF_W'(cen);
      ext_x  = pdd_pkg::DIFF_W'(ext);
      pad_x2 = pdd_pkg::DIFF_W'(pad) << 1;
      if (cc_ff[1]) begin
         diff = (cen_x <<< 1) + ext_x - $signed(pad_x2);
      end else begin
         diff = (cen_x <<< 1) - ext_x - $signed(pad_x2);
      end
   end

   assign inv_s = $signed({1'b0, cfg.inv_scale});
   assign prod  = diff_ff * inv_s;

   // Result assembly
   always_comb begin
      res.kind         = pdd_pkg::KIND_KP;
      res.point_number = pdd_pkg::PN_W'(kp_ff);
      res.x_first      = coord_ff[0];
      res.y_first      = coord_ff[1];
      res.x_second     = '0;
      res.y_second     = '0;
      res.score        = pdd_pkg::sat_score(opnd_ff[2]);
      res.last_result  = last_kp;
      if (none_ff) begin
         res.kind         = pdd_pkg::KIND_NONE;
         res.point_number = '0;
         res.x_first      = '0;
         res.y_first      = '0;
         res.score        = '0;
         res.last_result  = 1'b1;
      end else if (is_box_ff) begin
         res.kind         = pdd_pkg::KIND_BOX;
         res.point_number = '0;
         res.x_second     = coord_ff[2];
         res.y_second     = coord_ff[3];
         res.score        = pdd_pkg::sat_score(score_ff);
         res.last_result  = 1'b0;
      end
   end

   assign res_push = (state_ff == ST_PUSH) && !res_full;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      none_in   = none_ff;
      is_box_in = is_box_ff;
      kp_in     = kp_ff;
      base_in   = base_ff;
      slot_in   = slot_ff;
      cc_in     = cc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.valid) begin
               none_in   = !job.have_best;
               is_box_in = 1'b1;
               kp_in     = '0;
               base_in   = '0;
               slot_in   = '0;
               state_in  = job.have_best ? ST_READ : ST_PUSH;
            end
         end
         ST_READ: begin
            slot_in = slot_ff + SLOT_W'(1);
            if (slot_ff == last_slot) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            cc_in    = '0;
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cc_in    = cc_ff + SLOT_W'(1);
            state_in = (cc_ff == last_cc) ? ST_PUSH : ST_DIFF;
         end
         ST_PUSH: begin
            if (!res_full) begin
               slot_in = '0;
               if (none_ff || (!is_box_ff && last_kp)) begin
                  state_in = ST_IDLE;
               end else if (is_box_ff) begin
                  is_box_in = 1'b0;
                  kp_in     = '0;
                  base_in   = pdd_pkg::ENTRY_W'(pdd_pkg::KP_BASE);
                  state_in  = ST_READ;
               end else begin
                  kp_in     = kp_ff + pdd_pkg::KP_W'(1);
                  base_in   = base_ff + pdd_pkg::ENTRY_W'(pdd_pkg::KP_STRIDE);
                  state_in  = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         none_ff      <= 1'b0;
         is_box_ff    <= 1'b0;
         kp_ff        <= '0;
         base_ff      <= '0;
         slot_ff      <= '0;
         cc_ff        <= '0;
         cap_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         none_ff      <= none_in;
         is_box_ff    <= is_box_in;
         kp_ff        <= kp_in;
         base_ff      <= base_in;
         slot_ff      <= slot_in;
         cc_ff        <= cc_in;
         cap_valid_ff <= rd_en;
      end
   end

   // Datapath: operand capture, difference, product, rounded coordinate
   always_ff @(posedge clock) begin
      cap_slot_ff <= slot_ff;
      if (stat.take) begin
         score_ff <= job.score;
      end
      if (cap_valid_ff) begin
         opnd_ff[cap_slot_ff] <= $signed(rd_data);
      end
      if (state_ff == ST_DIFF) begin
         diff_ff <= diff;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod;
      end
      if (state_ff == ST_ROUND) begin
         coord_ff[cc_ff] <= pdd_pkg::round_sat(prod_ff);
      end
   end

endmodule

// ===== hdl/pdd_rsp_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: a short FIFO of decoded results between the back end and the result port.
// Uses pdd_pkg for the result type and depth.

module pdd_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pdd_pkg::result_type din,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output pdd_pkg::result_type dout
);

   localparam int PTR_W = (pdd_pkg::RSP_DEPTH > 1) ? $clog2(pdd_pkg::RSP_DEPTH) : 1;
   localparam int CNT_W = $clog2(pdd_pkg::RSP_DEPTH + 1);

   pdd_pkg::result_type mem_ff [pdd_pkg::RSP_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (int'(count_ff) == pdd_pkg::RSP_DEPTH);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == pdd_pkg::RSP_DEPTH - 1) ? '0
                                                               : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == pdd_pkg::RSP_DEPTH - 1) ? '0
                                                               : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
